[hw/rtl/glyph_coverage_downsampler_top_assert.svh]
// Assertion macros shared by the coverage downsampler RTL.
// No dependencies; SYNTH builds get empty bodies.
`ifndef GLYPH_COVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH
`define GLYPH_COVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GCDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define GCDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GCDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GCDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/gcds_pkg.sv]
// Types, codes and helper functions of the glyph coverage downsampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gcds_pkg;

   // item kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DIVISOR    = 2'd0;
   localparam logic [1:0] CSR_ROW_STRIDE = 2'd1;
   localparam logic [1:0] CSR_FULL       = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // divider: dividends up to 4095+1023, one quotient bit per step
   localparam int DIV_W     = 13;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_LANES = 4;

   // widest cell index: 4350 * 2047 + 5118 < 2^24
   localparam int CELL_W = 24;

   // jitter sample points in sixteenths of a cell
   localparam logic [3:0] JIT_X [8] = '{4'd9, 4'd1, 4'd5, 4'd11, 4'd11, 4'd15, 4'd7, 4'd3};
   localparam logic [3:0] JIT_Y [8] = '{4'd7, 4'd15, 4'd11, 4'd13, 4'd3, 4'd9, 4'd1, 4'd5};

   // 255*c/9 for c = 0..8
   localparam logic [7:0] LEVEL_NINTHS [9] = '{8'd0, 8'd28, 8'd56, 8'd85, 8'd113,
                                               8'd141, 8'd170, 8'd198, 8'd226};

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_DIV    = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_ADDR   = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic accept;    // latch request fields
      logic div_step;  // one restoring division step on all lanes
      logic mul;       // row times stride, hit count
      logic addr;      // add column to row base
      logic mem_rd;    // read the cell
      logic update;    // write new count, compute level
      logic load_rsp;  // load result register
      logic clr_step;  // zero one store entry
   } ctrl_cmd_type;

   typedef struct packed {
      logic oor;       // cell beyond the store
      logic clr_last;  // clearing pass at its last entry
   } dp_status_type;

   // normalized level 255*count/nd, saturated; d is the effective divisor
   function automatic logic [7:0] level_of(input logic [7:0] cnt, input logic [4:0] d);
      logic [15:0] prod;
      logic [7:0]  lv;
      prod = {cnt, 8'b0} - {8'b0, cnt};
      priority if (d <= 5'd1) begin
         lv = (cnt != 8'd0) ? 8'd255 : 8'd0;
      end else if (d == 5'd2) begin
         lv = (cnt >= 8'd4) ? 8'd255 : prod[9:2];
      end else if (d == 5'd3) begin
         lv = (cnt >= 8'd9) ? 8'd255 : LEVEL_NINTHS[cnt[3:0]];
      end else begin
         lv = (cnt >= 8'd8) ? 8'd255 : prod[10:3];
      end
      return lv;
   endfunction

endpackage

[hw/rtl/gcds_ctrl.sv]
// Controller of the coverage downsampler: sequences one item through the datapath.
// Depends on gcds_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "glyph_coverage_downsampler_top_assert.svh"

module gcds_ctrl
   import gcds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_kind,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   state_type   state_ff, state_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        div_last;

   assign div_last  = (div_cnt_ff == 4'(DIV_STEPS - 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (req_kind == KIND_PIXEL) begin
                  state_in = ST_DIV;
               end else if (req_kind == KIND_READ || req_kind == KIND_CLEAR) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_last) begin
               div_cnt_in = 4'd0;
               state_in   = ST_MUL;
            end else begin
               div_cnt_in = div_cnt_ff + 4'd1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (status.oor) begin
               state_in = ST_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         div_cnt_ff   <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GCDS_ASSERT_NXT(a_accept_goes_busy, clock, reset, req_valid && req_ready, (state_ff == ST_DIV || state_ff == ST_READ || state_ff == ST_RESP), "accepted item did not start")
   `GCDS_ASSERT_NXT(a_div_holds, clock, reset, state_ff == ST_DIV && !div_last, state_ff == ST_DIV, "division left early")
   `GCDS_ASSERT_NXT(a_resp_waits, clock, reset, state_ff == ST_RESP && rsp_valid_ff && !rsp_ready, state_ff == ST_RESP && rsp_valid_ff, "result overwritten while stalled")

endmodule

[hw/rtl/gcds_dpath.sv]
// Datapath of the coverage downsampler: divider lanes, cell address, store, level.
// Depends on gcds_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "glyph_coverage_downsampler_top_assert.svh"

module gcds_dpath
   import gcds_pkg::*;
#(
   parameter int CELL_COUNT = 32768
)(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [4:0]    divisor,
   input  logic [10:0]   row_stride,
   input  logic          full_sample,
   input  logic [1:0]    req_kind,
   input  logic [7:0]    req_source_byte,
   input  logic [9:0]    req_glyph_x,
   input  logic [7:0]    req_glyph_y,
   input  logic [10:0]   req_glyph_width,
   input  logic [8:0]    req_glyph_height,
   input  logic [11:0]   req_origin_x,
   input  logic [11:0]   req_origin_y,
   input  logic [14:0]   req_cell_req,
   output logic [14:0]   rsp_cell_used,
   output logic [3:0]    rsp_hits,
   output logic [7:0]    rsp_count,
   output logic [7:0]    rsp_level,
   output logic          rsp_out_of_range
);

   localparam int AW = $clog2(CELL_COUNT);

   logic [7:0]        mem [CELL_COUNT];

   logic [1:0]        kind_ff;
   logic              pix_on_ff;
   logic [DIV_W-1:0]  quo_ff [DIV_LANES];
   logic [4:0]        rem_ff [DIV_LANES];
   logic [CELL_W-1:0] prod_ff;
   logic [CELL_W-1:0] cell_ff;
   logic [3:0]        hits_ff, hits_in;
   logic [7:0]        rd_ff;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        level_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic [14:0]       rsp_cell_ff;
   logic [3:0]        rsp_hits_ff;
   logic [7:0]        rsp_count_ff;
   logic [7:0]        rsp_level_ff;
   logic              rsp_oor_ff;

   logic [4:0]        d_eff;
   logic              oor;
   logic              pix_on_in;
   logic [8:0]        sum;

   assign d_eff = (divisor == 5'd0) ? 5'd1 : divisor;
   assign oor   = (cell_ff >= CELL_W'(CELL_COUNT));

   assign status.oor      = oor;
   assign status.clr_last = (clr_addr_ff == AW'(CELL_COUNT - 1));

   // pixel inside the glyph and its bit set
   assign pix_on_in = ({1'b0, req_glyph_x} < req_glyph_width)
                   && ({1'b0, req_glyph_y} < req_glyph_height)
                   && req_source_byte[3'd7 - req_glyph_x[2:0]];

   // latch request; restoring division steps on four lanes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         pix_on_ff <= pix_on_in;
         quo_ff[0] <= {3'b0, req_glyph_x} + {1'b0, req_origin_x};
         quo_ff[1] <= {5'b0, req_glyph_y} + {1'b0, req_origin_y};
         quo_ff[2] <= {3'b0, req_glyph_x};
         quo_ff[3] <= {5'b0, req_glyph_y};
         for (int l = 0; l < DIV_LANES; l++) rem_ff[l] <= 5'd0;
      end else if (cmd.div_step) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            if ({rem_ff[l], quo_ff[l][DIV_W-1]} >= {1'b0, d_eff}) begin
               rem_ff[l] <= 5'({rem_ff[l], quo_ff[l][DIV_W-1]} - {1'b0, d_eff});
               quo_ff[l] <= {quo_ff[l][DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[l] <= {rem_ff[l][3:0], quo_ff[l][DIV_W-1]};
               quo_ff[l] <= {quo_ff[l][DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   // hits from jitter points matched by the in-cell remainders
   always_comb begin
      logic [8:0] tx;
      logic [8:0] ty;
      hits_in = 4'd0;
      for (int i = 0; i < 8; i++) begin
         tx = {4'b0, d_eff} * {5'b0, JIT_X[i]};
         ty = {4'b0, d_eff} * {5'b0, JIT_Y[i]};
         if (rem_ff[2] == tx[8:4] && rem_ff[3] == ty[8:4]) hits_in = hits_in + 4'd1;
      end
      if (!pix_on_ff) begin
         hits_in = 4'd0;
      end else if (full_sample || d_eff <= 5'd3) begin
         hits_in = 4'd1;
      end
   end

   // new count: saturating add, or zero on clear
   assign sum      = {1'b0, rd_ff} + {5'b0, hits_ff};
   assign count_in = (kind_ff == KIND_CLEAR) ? 8'd0 : (sum[8] ? 8'd255 : sum[7:0]);

   // cell address, hits, count and level
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hits_ff  <= 4'd0;
         count_ff <= 8'd0;
         level_ff <= 8'd0;
         if (req_kind == KIND_READ || req_kind == KIND_CLEAR) begin
            cell_ff <= {9'b0, req_cell_req};
         end else begin
            cell_ff <= '0;
         end
      end
      if (cmd.mul) begin
         prod_ff <= {11'b0, quo_ff[1]} * {13'b0, row_stride};
         hits_ff <= hits_in;
      end
      if (cmd.addr) cell_ff <= prod_ff + {11'b0, quo_ff[0]};
      if (cmd.update) begin
         count_ff <= count_in;
         level_ff <= level_of(count_in, d_eff);
      end
   end

   // coverage store: one read, one write port
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rd_ff <= mem[cell_ff[AW-1:0]];
      if (cmd.clr_step) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (cmd.update) begin
         mem[cell_ff[AW-1:0]] <= count_in;
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cell_ff  <= cell_ff[14:0];
         rsp_hits_ff  <= oor ? 4'd0 : hits_ff;
         rsp_count_ff <= count_ff;
         rsp_level_ff <= level_ff;
         rsp_oor_ff   <= oor;
      end
   end

   assign rsp_cell_used    = rsp_cell_ff;
   assign rsp_hits         = rsp_hits_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   `GCDS_ASSERT_IMP(a_store_in_range, clock, reset, cmd.mem_rd || cmd.update, !oor, "store access beyond the store")
   `GCDS_ASSERT_IMP(a_hits_bound, clock, reset, cmd.load_rsp, hits_ff <= 4'd8, "more than eight hits")
   `GCDS_ASSERT_NXT(a_level_zero_count, clock, reset, cmd.update && count_in == 8'd0, level_ff == 8'd0, "nonzero level for empty cell")

endmodule

[hw/rtl/glyph_coverage_downsampler_top.sv]
// Top level of the glyph coverage downsampler: configuration registers,
// controller and datapath. Depends on gcds_pkg, gcds_ctrl, gcds_dpath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  kind, pixel, glyph and cell fields
//   rsp_      out        rsp_valid / rsp_ready  cell_used, hits, count, level, out_of_range
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Pixel items pass through the four-lane shift-subtract divider and the multiply,
// address, read, update and result states; read and clear items start at read.
// After reset the store is zeroed one entry per cycle, with req_ready low until
// the last entry is cleared. Configuration writes are always taken.
// The result register holds a finished item while the next one is accepted;
// a stalled result blocks only the final load of the following item.
`timescale 1ns / 1ps

module glyph_coverage_downsampler_top
   import gcds_pkg::*;
#(
   parameter int CELL_COUNT = 32768
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_source_byte,
   input  logic [9:0]            req_glyph_x,
   input  logic [7:0]            req_glyph_y,
   input  logic [10:0]           req_glyph_width,
   input  logic [8:0]            req_glyph_height,
   input  logic [11:0]           req_origin_x,
   input  logic [11:0]           req_origin_y,
   input  logic [14:0]           req_cell_req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [14:0]           rsp_cell_used,
   output logic [3:0]            rsp_hits,
   output logic [7:0]            rsp_count,
   output logic [7:0]            rsp_level,
   output logic                  rsp_out_of_range,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [4:0]    divisor_ff;
   logic [10:0]   row_stride_ff;
   logic          full_sample_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff     <= 5'd4;
         row_stride_ff  <= 11'd400;
         full_sample_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIVISOR:    divisor_ff     <= csr_wdata[4:0];
            CSR_ROW_STRIDE: row_stride_ff  <= csr_wdata[10:0];
            CSR_FULL:       full_sample_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   gcds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   gcds_dpath #(
      .CELL_COUNT (CELL_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .divisor          (divisor_ff),
      .row_stride       (row_stride_ff),
      .full_sample      (full_sample_ff),
      .req_kind         (req_kind),
      .req_source_byte  (req_source_byte),
      .req_glyph_x      (req_glyph_x),
      .req_glyph_y      (req_glyph_y),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_cell_req     (req_cell_req),
      .rsp_cell_used    (rsp_cell_used),
      .rsp_hits         (rsp_hits),
      .rsp_count        (rsp_count),
      .rsp_level        (rsp_level),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

[tb/sv/glyph_coverage_downsampler_top_tb.sv]
// Self-checking testbench for glyph_coverage_downsampler_top: directed and random
// pixel, read and clear transfers across several register settings.
// Depends on gcds_pkg and the glyph_coverage_downsampler_top RTL.
`timescale 1ns / 1ps

module glyph_coverage_downsampler_top_tb;
   import gcds_pkg::*;

   localparam int          STORE_CELLS  = 32768;
   localparam logic [1:0]  KIND_NONE    = 2'd3;   // ignored kind, all-zero response
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;   // unmapped register index
   localparam int          STALL_LIMIT  = 100000; // covers the store clearing pass
   localparam int          LONG_HOLD    = 400;
   // jitter points in sixteenths, entry 0 in the top nibble
   localparam logic [31:0] JITTER_X     = 32'h915B_BF73;
   localparam logic [31:0] JITTER_Y     = 32'h7FBD_3915;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  source_byte;
      logic [9:0]  glyph_x;
      logic [7:0]  glyph_y;
      logic [10:0] glyph_width;
      logic [8:0]  glyph_height;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [14:0] cell_req;
   } request_type;

   typedef struct packed {
      logic [14:0] cell_used;
      logic [3:0]  hits;
      logic [7:0]  count;
      logic [7:0]  level;
      logic        out_of_range;
   } response_type;

   // Coverage store model and in-order queue of expected responses
   class coverage_scoreboard;
      bit [7:0]     cells [STORE_CELLS];
      bit [4:0]     divisor     = 5'd4;
      bit [10:0]    row_stride  = 11'd400;
      bit           full_sample = 1'b0;
      response_type expected_responses [$];
      int unsigned  errors       = 0;
      int unsigned  results_seen = 0;
      int unsigned  last_cell    = 0;

      function void write_register(logic [1:0] idx, logic [10:0] data);
         case (idx)
            CSR_DIVISOR:    divisor     = data[4:0];
            CSR_ROW_STRIDE: row_stride  = data;
            CSR_FULL:       full_sample = data[0];
            default: ;
         endcase
      endfunction

      // zero divisor acts as one
      function int unsigned shrink();
         return (divisor == 5'd0) ? 1 : divisor;
      endfunction

      function int unsigned pixel_cell(request_type r);
         int unsigned px, py, d;
         d  = shrink();
         px = r.glyph_x + r.origin_x;
         py = r.glyph_y + r.origin_y;
         return (py / d) * row_stride + px / d;
      endfunction

      function bit [7:0] level_for(int unsigned cnt, int unsigned d);
         int unsigned nd, lv;
         nd = (d <= 3) ? d * d : 8;
         lv = (255 * cnt) / nd;
         return (lv > 255) ? 8'd255 : lv[7:0];
      endfunction

      // update the store for an accepted request and queue its response
      function void note_request(request_type r);
         int unsigned  d, cell_idx, hits, cnt, jx, jy;
         response_type exp;
         d        = shrink();
         cell_idx = 0;
         hits     = 0;
         exp      = '0;
         if (r.kind == KIND_PIXEL) begin
            cell_idx = pixel_cell(r);
            if (cell_idx >= STORE_CELLS) begin
               exp.out_of_range = 1'b1;
            end else begin
               if (r.glyph_x < r.glyph_width && r.glyph_y < r.glyph_height &&
                   r.source_byte[3'd7 - r.glyph_x[2:0]]) begin
                  if (full_sample || d <= 3) begin
                     hits = 1;
                  end else begin
                     for (int i = 0; i < 8; i++) begin
                        jx = JITTER_X[31 - 4 * i -: 4];
                        jy = JITTER_Y[31 - 4 * i -: 4];
                        if (r.glyph_x % d == (d * jx) / 16 && r.glyph_y % d == (d * jy) / 16)
                           hits++;
                     end
                  end
               end
               cnt = cells[cell_idx] + hits;
               if (cnt > 255) cnt = 255;
               cells[cell_idx] = cnt[7:0];
               last_cell       = cell_idx;
               exp.hits        = hits[3:0];
               exp.count       = cnt[7:0];
               exp.level       = level_for(cnt, d);
            end
         end else if (r.kind == KIND_READ || r.kind == KIND_CLEAR) begin
            cell_idx = r.cell_req;
            if (cell_idx >= STORE_CELLS) begin
               exp.out_of_range = 1'b1;
            end else begin
               if (r.kind == KIND_CLEAR) cells[cell_idx] = 8'd0;
               exp.count = cells[cell_idx];
               exp.level = level_for(cells[cell_idx], d);
            end
         end
         exp.cell_used = cell_idx[14:0];
         expected_responses.push_back(exp);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(response_type got);
         response_type exp;
         results_seen++;
         if (expected_responses.size() == 0) begin
            $display("%0t unexpected response: expected none, actual cell_used %0d",
                     $time, got.cell_used);
            errors++;
            return;
         end
         exp = expected_responses.pop_front();
         compare_field("cell_used", exp.cell_used, got.cell_used);
         compare_field("hits", exp.hits, got.hits);
         compare_field("count", exp.count, got.count);
         compare_field("level", exp.level, got.level);
         compare_field("out_of_range", exp.out_of_range, got.out_of_range);
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind         = '0;
   logic [7:0]            req_source_byte  = '0;
   logic [9:0]            req_glyph_x      = '0;
   logic [7:0]            req_glyph_y      = '0;
   logic [10:0]           req_glyph_width  = '0;
   logic [8:0]            req_glyph_height = '0;
   logic [11:0]           req_origin_x     = '0;
   logic [11:0]           req_origin_y     = '0;
   logic [14:0]           req_cell_req     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [14:0]           rsp_cell_used;
   logic [3:0]            rsp_hits;
   logic [7:0]            rsp_count;
   logic [7:0]            rsp_level;
   logic                  rsp_out_of_range;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   coverage_scoreboard sb = new();
   int                 phase_no = 0;
   int                 idle_cycles = 0;

   glyph_coverage_downsampler_top #(.CELL_COUNT(STORE_CELLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_source_byte(req_source_byte),
      .req_glyph_x(req_glyph_x), .req_glyph_y(req_glyph_y),
      .req_glyph_width(req_glyph_width), .req_glyph_height(req_glyph_height),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_cell_req(req_cell_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cell_used(rsp_cell_used), .rsp_hits(rsp_hits), .rsp_count(rsp_count),
      .rsp_level(rsp_level), .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall watchdog: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random back-pressure (none in every third phase) plus one long hold-off
   initial begin : response_side
      int unsigned  wait_cycles;
      bit           long_hold_done;
      response_type got;
      long_hold_done = 1'b0;
      forever begin
         if (!long_hold_done && sb.results_seen >= 150) begin
            wait_cycles    = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (phase_no % 3 == 2) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 5);
         end
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         got.cell_used    = rsp_cell_used;
         got.hits         = rsp_hits;
         got.count        = rsp_count;
         got.level        = rsp_level;
         got.out_of_range = rsp_out_of_range;
         sb.check_response(got);
      end
   end

   task automatic send_item(input request_type r);
      int unsigned gap;
      gap = (phase_no % 3 == 1) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind         <= r.kind;
      req_source_byte  <= r.source_byte;
      req_glyph_x      <= r.glyph_x;
      req_glyph_y      <= r.glyph_y;
      req_glyph_width  <= r.glyph_width;
      req_glyph_height <= r.glyph_height;
      req_origin_x     <= r.origin_x;
      req_origin_y     <= r.origin_y;
      req_cell_req     <= r.cell_req;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready === 1'b1));
      sb.note_request(r);
   endtask

   // stop offering and wait until every queued response has arrived
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [10:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready === 1'b1));
      sb.write_register(idx, data);
   endtask

   function automatic request_type make_pixel(logic [7:0] sbyte, logic [9:0] gx,
                                              logic [7:0] gy, logic [10:0] gw,
                                              logic [8:0] gh, logic [11:0] ox,
                                              logic [11:0] oy);
      request_type r;
      r              = '0;
      r.kind         = KIND_PIXEL;
      r.source_byte  = sbyte;
      r.glyph_x      = gx;
      r.glyph_y      = gy;
      r.glyph_width  = gw;
      r.glyph_height = gh;
      r.origin_x     = ox;
      r.origin_y     = oy;
      return r;
   endfunction

   function automatic request_type make_cell_op(logic [1:0] kind, logic [14:0] idx);
      request_type r;
      r          = '0;
      r.kind     = kind;
      r.cell_req = idx;
      return r;
   endfunction

   // mostly in-range pixel strokes, some reads and clears, the rest raw noise
   function automatic request_type random_request(bit hot);
      request_type r;
      logic [95:0] noise;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (hot) begin
         // every pixel lands in cell 0 to drive the count into saturation
         if (sel < 92)
            r = make_pixel(8'hFF, 10'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           11'd1024, 9'd256, 12'd0, 12'd0);
         else
            r = make_cell_op(KIND_READ, 15'd0);
      end else if (sel < 68) begin
         r = make_pixel(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 255)),
                        10'd0, 8'd0, 11'd1024, 9'd256, 12'd0, 12'd0);
         if ($urandom_range(0, 7) == 0) r.glyph_width  = 11'($urandom_range(0, 64));
         if ($urandom_range(0, 7) == 0) r.glyph_height = 9'($urandom_range(0, 32));
         for (int tries = 0; tries < 16; tries++) begin
            r.glyph_x  = 10'($urandom_range(0, 63));
            r.glyph_y  = 8'($urandom_range(0, 31));
            r.origin_x = 12'($urandom_range(0, 40));
            r.origin_y = 12'($urandom_range(0, 40));
            if (sb.pixel_cell(r) < STORE_CELLS) break;
         end
      end else if (sel < 88) begin
         r = make_cell_op((sel < 84) ? KIND_READ : KIND_CLEAR,
                          $urandom_range(0, 1) ? sb.last_cell[14:0]
                                               : 15'($urandom_range(0, 32767)));
      end else begin
         noise = {$urandom, $urandom, $urandom};
         r     = noise[$bits(request_type)-1:0];
      end
      return r;
   endfunction

   task automatic run_phase(input int id, input logic [10:0] div, input logic [10:0] stride,
                            input logic full, input int n_items, input bit hot,
                            input bit poke_unused, input bit pause_mid);
      wait_results_drained();
      csr_write(CSR_DIVISOR, div);
      csr_write(CSR_ROW_STRIDE, stride);
      csr_write(CSR_FULL, {10'd0, full});
      if (poke_unused) csr_write(CSR_UNUSED, 11'h7FF);
      csr_valid <= 1'b0;
      phase_no = id;
      for (int i = 0; i < n_items; i++) begin
         // sender pause: let the block empty completely mid-phase
         if (pause_mid && i == n_items / 2) wait_results_drained();
         send_item(random_request(hot));
      end
   endtask

   initial begin : stimulus
      request_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset settings: divisor 4, stride 400, jitter mode
      send_item(make_pixel(8'h20, 10'd2, 8'd1, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'hFF, 10'd2, 8'd1, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'hDF, 10'd2, 8'd1, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'hFF, 10'd2, 8'd1, 11'd2, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'hFF, 10'd2, 8'd1, 11'd1024, 9'd1, 12'd0, 12'd0));
      send_item(make_pixel(8'hFF, 10'd0, 8'd0, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'h01, 10'd7, 8'd3, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'h80, 10'd8, 8'd1, 11'd1024, 9'd256, 12'd0, 12'd0));
      send_item(make_pixel(8'h04, 10'd1021, 8'd2, 11'd1022, 9'd256, 12'd0, 12'd0));
      // last cell of the store, then one past it
      send_item(make_pixel(8'hFF, 10'd4, 8'd4, 11'd1024, 9'd256, 12'd1464, 12'd320));
      send_item(make_pixel(8'hFF, 10'd4, 8'd4, 11'd1024, 9'd256, 12'd1468, 12'd320));
      send_item(make_pixel(8'hFF, 10'd1023, 8'd255, 11'd1024, 9'd256, 12'hFFF, 12'hFFF));
      send_item(make_pixel(8'h00, 10'd0, 8'd0, 11'd0, 9'd0, 12'd0, 12'd0));
      send_item(make_cell_op(KIND_READ, 15'd0));
      send_item(make_cell_op(KIND_CLEAR, 15'd0));
      send_item(make_cell_op(KIND_READ, 15'd0));
      send_item(make_cell_op(KIND_READ, 15'd32767));
      send_item(make_cell_op(KIND_CLEAR, 15'd32767));
      r      = '1;
      r.kind = KIND_NONE;
      send_item(r);
      r.kind = KIND_READ;
      send_item(r);

      // random phases over register settings, extremes included
      run_phase(1, 11'd1,    11'd2047, 1'b0, 55,  1'b0, 1'b0, 1'b0);
      run_phase(2, 11'd0,    11'd0,    1'b0, 55,  1'b0, 1'b0, 1'b0);
      run_phase(3, 11'd3,    11'd1,    1'b0, 55,  1'b0, 1'b0, 1'b0);
      run_phase(4, 11'd16,   11'd1024, 1'b0, 55,  1'b0, 1'b0, 1'b0);
      run_phase(5, 11'h7FF,  11'd100,  1'b0, 55,  1'b0, 1'b1, 1'b0);
      run_phase(6, 11'd4,    11'd64,   1'b1, 345, 1'b1, 1'b0, 1'b0);
      run_phase(7, 11'd5,    11'd400,  1'b0, 55,  1'b0, 1'b0, 1'b1);
      run_phase(8, 11'd2,    11'd5,    1'b1, 55,  1'b0, 1'b0, 1'b0);

      wait_results_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/gcds_pkg.sv
hw/rtl/gcds_ctrl.sv
hw/rtl/gcds_dpath.sv
hw/rtl/glyph_coverage_downsampler_top.sv
tb/sv/glyph_coverage_downsampler_top_tb.sv
